// ===== sv/tup_pkg.sv =====
package tup_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // radix codes
  localparam logic [4:0] RADIX_AUTO = 5'd0;
  localparam logic [4:0] RADIX_ONE  = 5'd1;
  localparam logic [4:0] RADIX_MIN  = 5'd2;
  localparam logic [4:0] RADIX_DEC  = 5'd10;
  localparam logic [4:0] RADIX_HEX  = 5'd16;

  // digit value meaning "not a digit"
  localparam logic [4:0] NOT_DIGIT = 5'd16;

  localparam int unsigned ACC_W  = 64;
  localparam int unsigned PROD_W = ACC_W + 5;

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] radix;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [ACC_W-1:0]  number;
  } out_t;

  typedef struct packed {
    logic emit;
    out_t res;
  } step_t;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_ZERO  = 6'b000100,
    PH_DIGIT = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + 8'd10;
    end else begin
      v = {3'b000, NOT_DIGIT};
    end
    return v[4:0];
  endfunction

endpackage

// ===== sv/tup_mac.sv =====
module tup_mac (
  input  logic [7:0]               ch,
  input  logic [4:0]               radix,
  input  logic [tup_pkg::ACC_W-1:0] acc,
  output logic                     is_digit,
  output logic                     reject,
  output logic [tup_pkg::ACC_W-1:0] sum
);

  logic [4:0]                  dval;
  logic [tup_pkg::PROD_W-1:0]  wide;

  assign dval     = tup_pkg::digit_value(ch);
  assign is_digit = (dval != tup_pkg::NOT_DIGIT);

  // acc * radix + digit, with the top bits showing overflow past 64 bits
  assign wide = {5'b00000, acc} * {{(tup_pkg::PROD_W-5){1'b0}}, radix}
              + {{(tup_pkg::PROD_W-5){1'b0}}, dval};

  assign sum    = wide[tup_pkg::ACC_W-1:0];
  assign reject = (radix < tup_pkg::RADIX_MIN) || (dval >= radix)
               || (|wide[tup_pkg::PROD_W-1:tup_pkg::ACC_W]);

endmodule

// ===== sv/tup_ctrl.sv =====
module tup_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  tup_pkg::in_t  item,
  output tup_pkg::step_t step
);

  tup_pkg::phase_t             phase, phase_next, ph_s;
  logic [tup_pkg::ACC_W-1:0]   accumulator, accumulator_next, acc_s, acc_d, mac_sum;
  logic                        seen_digit, seen_digit_next, seen_s, seen_d;
  logic [4:0]                  active_radix, active_radix_next, ar_s, ar_d;
  logic                        mac_is_digit, mac_reject;
  logic [7:0]                  c;

  assign c = item.ch;

  // state as seen by this character, with a fresh text folded in
  always_comb begin
    ph_s   = phase;
    acc_s  = accumulator;
    seen_s = seen_digit;
    ar_s   = active_radix;
    if (phase == tup_pkg::PH_START) begin
      acc_s  = '0;
      seen_s = 1'b0;
      ar_s   = item.radix;
      if (item.radix == tup_pkg::RADIX_ONE || item.radix > tup_pkg::RADIX_HEX) begin
        ph_s = tup_pkg::PH_ERROR;
      end else begin
        ph_s = tup_pkg::PH_LEAD;
      end
    end
    ar_d   = ar_s;
    acc_d  = acc_s;
    seen_d = seen_s;
    if (ph_s == tup_pkg::PH_LEAD && ar_s == tup_pkg::RADIX_AUTO) begin
      ar_d = tup_pkg::RADIX_DEC;
    end else if (ph_s == tup_pkg::PH_ZERO) begin
      ar_d   = tup_pkg::RADIX_DEC;
      acc_d  = '0;
      seen_d = 1'b1;
    end
  end

  tup_mac u_mac (
    .ch       (c),
    .radix    (ar_d),
    .acc      (acc_d),
    .is_digit (mac_is_digit),
    .reject   (mac_reject),
    .sum      (mac_sum)
  );

  always_comb begin
    logic dig_run;
    logic fin;
    logic good;
    dig_run           = 1'b0;
    fin               = 1'b0;
    good              = 1'b0;
    phase_next        = ph_s;
    accumulator_next  = acc_s;
    seen_digit_next   = seen_s;
    active_radix_next = ar_s;
    unique case (ph_s)
      tup_pkg::PH_LEAD: begin
        if (tup_pkg::is_blank(c)) begin
          phase_next = tup_pkg::PH_LEAD;
        end else if (c == tup_pkg::CH_NUL) begin
          fin = 1'b1;
        end else if (ar_s == tup_pkg::RADIX_AUTO && c == tup_pkg::CH_ZERO) begin
          phase_next = tup_pkg::PH_ZERO;
        end else begin
          dig_run = 1'b1;
        end
      end
      tup_pkg::PH_ZERO: begin
        if (c == tup_pkg::CH_LX || c == tup_pkg::CH_UX) begin
          active_radix_next = tup_pkg::RADIX_HEX;
          phase_next        = tup_pkg::PH_DIGIT;
        end else begin
          dig_run = 1'b1;
        end
      end
      tup_pkg::PH_DIGIT: begin
        dig_run = 1'b1;
      end
      tup_pkg::PH_TRAIL: begin
        if (tup_pkg::is_blank(c)) begin
          phase_next = tup_pkg::PH_TRAIL;
        end else if (c == tup_pkg::CH_NUL) begin
          fin  = 1'b1;
          good = seen_s;
        end else begin
          phase_next = tup_pkg::PH_ERROR;
        end
      end
      default: begin
        // error phase and unused codes
        if (c == tup_pkg::CH_NUL) begin
          fin = 1'b1;
        end else begin
          phase_next = tup_pkg::PH_ERROR;
        end
      end
    endcase

    if (dig_run) begin
      active_radix_next = ar_d;
      accumulator_next  = acc_d;
      seen_digit_next   = seen_d;
      if (mac_is_digit) begin
        if (mac_reject) begin
          phase_next = tup_pkg::PH_ERROR;
        end else begin
          accumulator_next = mac_sum;
          seen_digit_next  = 1'b1;
          phase_next       = tup_pkg::PH_DIGIT;
        end
      end else if (c == tup_pkg::CH_NUL) begin
        fin  = 1'b1;
        good = seen_d;
      end else if (tup_pkg::is_blank(c)) begin
        phase_next = tup_pkg::PH_TRAIL;
      end else begin
        phase_next = tup_pkg::PH_ERROR;
      end
    end

    step.emit       = fin;
    step.res.ok     = fin && good;
    step.res.number = (fin && good) ? accumulator_next : '0;

    if (fin) begin
      phase_next        = tup_pkg::PH_START;
      accumulator_next  = '0;
      seen_digit_next   = 1'b0;
      active_radix_next = tup_pkg::RADIX_AUTO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tup_pkg::PH_START;
      accumulator  <= '0;
      seen_digit   <= 1'b0;
      active_radix <= tup_pkg::RADIX_AUTO;
    end else if (fire) begin
      phase        <= phase_next;
      accumulator  <= accumulator_next;
      seen_digit   <= seen_digit_next;
      active_radix <= active_radix_next;
    end
  end

endmodule

// ===== sv/text_to_u64_parser_top.sv =====
// channel  | signals                               | payload
// ---------+---------------------------------------+------------------------
// char     | char_valid in, char_stall out         | char_data   (ch, radix)
// result   | result_valid out, result_stall in     | result_data (ok, number)
//
// one character per cycle while char_stall is low: a transfer lands in the
// input register, from which the parser state and the 64-bit multiply-add by
// the radix update, and a terminator loads the result register
// result valid is registered from the step of the terminator
// rst is synchronous and returns the parser to the start of a new text
// char_stall rises only when the input register holds a terminator while
// the result register is full and stalled; other characters never wait
module text_to_u64_parser_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_stall,
  input  tup_pkg::in_t  char_data,
  output logic          result_valid,
  input  logic          result_stall,
  output tup_pkg::out_t result_data
);

  // input register
  logic          in_vld;
  tup_pkg::in_t  in_q;

  // parser step
  tup_pkg::step_t step;
  logic           step_fire;

  // a step may go unless it needs the result register and that is blocked
  assign step_fire  = in_vld && (!step.emit || !result_valid || !result_stall);
  assign char_stall = in_vld && !step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!char_stall) begin
      in_vld <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      in_q <= char_data;
    end
  end

  tup_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (step_fire),
    .item (in_q),
    .step (step)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_fire && step.emit) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step.emit) begin
      result_data <= step.res;
    end
  end

  // results come only from a terminator
  a_emit_on_nul: assert property (@(posedge clk) disable iff (rst)
    (step_fire && step.emit) |-> (in_q.ch == tup_pkg::CH_NUL))
    else $error("result produced by a character other than the terminator");

  // a failed result carries zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.ok || result_data.number == '0))
    else $error("failed result with nonzero number");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(step_fire && step.emit))
    else $error("result register overwritten while stalled");

  // the input side waits only on a terminator held in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (in_vld && step.emit))
    else $error("input stalled without a pending terminator");

endmodule
